// ===== hw/rtl/pcng_pkg.sv =====
// ----------------------------------------------------------------------------
// pcng_pkg: shared types and constants of the periodic cell neighbor generator
// Holds the register map, the neighbor slot table and the queue status type.
// ----------------------------------------------------------------------------
package pcng_pkg;

  // Register map of the configuration port
  localparam int unsigned CfgIdxW      = 3;
  localparam int unsigned CfgDataW     = 32;
  localparam logic [CfgIdxW-1:0] REG_CELLS_X    = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_CELLS_Y    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_CELLS_Z    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_INV_SIZE_X = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_INV_SIZE_Y = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_INV_SIZE_Z = 3'd5;

  localparam int unsigned CountW = 7;
  localparam int unsigned PosW   = 32;
  localparam int unsigned InvW   = 32;

  // Result fields
  localparam int unsigned SlotW    = 5;
  localparam int unsigned IdxW     = 18;
  localparam int unsigned NumSlots = 27;
  localparam int unsigned LayerSlots = 9;
  localparam logic [SlotW-1:0] LAST_SLOT = SlotW'(NumSlots - 1);

  // Neighbor selector per axis: same cell, wrapped up, wrapped down
  typedef enum logic [1:0] {
    SEL_SAME = 2'd0,
    SEL_UP   = 2'd1,
    SEL_DOWN = 2'd2
  } sel_e;

  // (y, x) selector pair of each slot within one z layer
  localparam sel_e YSEL [LayerSlots] = '{SEL_SAME, SEL_SAME, SEL_SAME, SEL_UP, SEL_DOWN,
                                         SEL_UP, SEL_UP, SEL_DOWN, SEL_DOWN};
  localparam sel_e XSEL [LayerSlots] = '{SEL_SAME, SEL_UP, SEL_DOWN, SEL_SAME, SEL_SAME,
                                         SEL_UP, SEL_DOWN, SEL_UP, SEL_DOWN};

  // Status of a queue
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== hw/rtl/pcng_fifo.sv =====
// ----------------------------------------------------------------------------
// pcng_fifo: small register queue
// First-in first-out buffer with occupancy count and full/empty status.
// ----------------------------------------------------------------------------
module pcng_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CNTW = $clog2(DEPTH + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  logic [WIDTH-1:0]     wdata_i,
  input  logic                 pop_i,
  output logic [WIDTH-1:0]     rdata_o,
  output pcng_pkg::q_status_t  status_o,
  output logic [CNTW-1:0]      count_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CNTW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign status_o.full  = (cnt_q == CNTW'(DEPTH));
  assign status_o.empty = (cnt_q == '0);
  assign count_o        = cnt_q;
  assign do_push        = push_i & ~status_o.full;
  assign do_pop         = pop_i & ~status_o.empty;
  assign rdata_o        = mem_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store written entry
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ===== hw/rtl/pcng_front.sv =====
// ----------------------------------------------------------------------------
// pcng_front: position to cell coordinate front end
// Scales each coordinate by the inverse cell size, saturates it to the last
// cell and forms the wrapped up and down neighbors for the back end queue.
// ----------------------------------------------------------------------------
module pcng_front #(
  parameter int unsigned MAX_CELLS_PER_AXIS = 64,
  localparam int unsigned CW = (MAX_CELLS_PER_AXIS > 1) ? $clog2(MAX_CELLS_PER_AXIS) : 1,
  localparam int unsigned NW = $clog2(MAX_CELLS_PER_AXIS + 1)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  logic [pcng_pkg::PosW-1:0] pos_x_i,
  input  logic [pcng_pkg::PosW-1:0] pos_y_i,
  input  logic [pcng_pkg::PosW-1:0] pos_z_i,
  output logic                      full_o,
  input  logic [2:0][NW-1:0]        cnt_i,
  input  logic [2:0][pcng_pkg::InvW-1:0] inv_i,
  output logic                      q_push_o,
  output logic [2:0][2:0][CW-1:0]   q_wdata_o,
  input  pcng_pkg::q_status_t       q_status_i
);

  localparam int unsigned ProdW = pcng_pkg::PosW + pcng_pkg::InvW;

  logic                  p_vld_q, p_vld_d;
  logic [2:0][ProdW-1:0] prod_q;
  logic [2:0][pcng_pkg::PosW-1:0] pos;
  logic                  p_adv;

  assign pos    = {pos_z_i, pos_y_i, pos_x_i};
  assign p_adv  = ~p_vld_q | ~q_status_i.full;
  assign full_o = ~p_adv;

  // Hold the product stage while the queue is full
  always_comb begin
    p_vld_d = p_vld_q;
    if (p_adv) begin
      p_vld_d = push_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
    end else begin
      p_vld_q <= p_vld_d;
    end
  end

  // Scale each axis: Q16.16 times Q16.16 gives Q32.32
  always_ff @(posedge clk_i) begin
    if (p_adv && push_i) begin
      for (int a = 0; a < 3; a++) begin
        prod_q[a] <= ProdW'(pos[a]) * ProdW'(inv_i[a]);
      end
    end
  end

  // Saturate to the last cell and form wrapped neighbors
  always_comb begin
    logic [pcng_pkg::PosW-1:0] c_raw;
    logic [CW-1:0]             c;
    logic [NW-1:0]             c_up;
    for (int a = 0; a < 3; a++) begin
      c_raw = prod_q[a][ProdW-1:pcng_pkg::InvW];
      if (c_raw >= pcng_pkg::PosW'(cnt_i[a])) begin
        c = CW'(cnt_i[a] - 1'b1);
      end else begin
        c = CW'(c_raw);
      end
      c_up = NW'(c) + 1'b1;
      q_wdata_o[a][pcng_pkg::SEL_SAME] = c;
      q_wdata_o[a][pcng_pkg::SEL_UP]   = (c_up >= cnt_i[a]) ? '0 : CW'(c_up);
      q_wdata_o[a][pcng_pkg::SEL_DOWN] = (c == '0) ? CW'(cnt_i[a] - 1'b1) : c - 1'b1;
    end
  end

  assign q_push_o = p_vld_q & ~q_status_i.full;

endmodule

// ===== hw/rtl/pcng_back.sv =====
// ----------------------------------------------------------------------------
// pcng_back: neighbor index sequencer
// Walks the 27 neighbor slots of the queued cell and computes each linear
// cell index in two registered steps into the result queue.
// ----------------------------------------------------------------------------
module pcng_back #(
  parameter int unsigned MAX_CELLS_PER_AXIS = 64,
  parameter int unsigned OUT_DEPTH = 4,
  localparam int unsigned CW = (MAX_CELLS_PER_AXIS > 1) ? $clog2(MAX_CELLS_PER_AXIS) : 1,
  localparam int unsigned NW = $clog2(MAX_CELLS_PER_AXIS + 1),
  localparam int unsigned OCW = $clog2(OUT_DEPTH + 1),
  localparam int unsigned OW = pcng_pkg::SlotW + pcng_pkg::IdxW + 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [2:0][NW-1:0]      cnt_i,
  input  logic [2:0][2:0][CW-1:0] q_rdata_i,
  input  pcng_pkg::q_status_t     q_status_i,
  output logic                    q_pop_o,
  output logic                    out_push_o,
  output logic [OW-1:0]           out_wdata_o,
  input  logic [OCW-1:0]          out_count_i
);

  localparam int unsigned ZW = CW + NW;
  localparam int unsigned IW = ZW + NW;

  logic [1:0]                   layer_q, layer_d;
  logic [3:0]                   pos_q, pos_d;
  logic [pcng_pkg::SlotW-1:0]   slot_q, slot_d;
  logic                         issue, slot_last;
  logic [CW-1:0]                xv, yv, zv;
  logic                         a_vld_q;
  logic [pcng_pkg::SlotW-1:0]   a_slot_q;
  logic [ZW-1:0]                a_zy_q;
  logic [CW-1:0]                a_x_q;
  logic [IW-1:0]                idx;

  function automatic logic [CW-1:0] pick(logic [2:0][CW-1:0] v, pcng_pkg::sel_e s);
    logic [CW-1:0] r;
    unique case (s)
      pcng_pkg::SEL_UP:   r = v[pcng_pkg::SEL_UP];
      pcng_pkg::SEL_DOWN: r = v[pcng_pkg::SEL_DOWN];
      default:            r = v[pcng_pkg::SEL_SAME];
    endcase
    return r;
  endfunction

  // Issue a slot when a cell is queued and the result queue has room for it and the one in flight
  assign issue = ~q_status_i.empty &
                 ((OCW'(a_vld_q) + out_count_i) < OCW'(OUT_DEPTH));
  assign slot_last = (slot_q == pcng_pkg::LAST_SLOT);
  assign q_pop_o   = issue & slot_last;

  // Advance slot, position within layer and layer
  always_comb begin
    slot_d  = slot_q;
    pos_d   = pos_q;
    layer_d = layer_q;
    if (issue) begin
      if (slot_last) begin
        slot_d  = '0;
        pos_d   = '0;
        layer_d = '0;
      end else begin
        slot_d = slot_q + 1'b1;
        if (pos_q == 4'(pcng_pkg::LayerSlots - 1)) begin
          pos_d   = '0;
          layer_d = layer_q + 1'b1;
        end else begin
          pos_d = pos_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q  <= '0;
      pos_q   <= '0;
      layer_q <= '0;
      a_vld_q <= 1'b0;
    end else begin
      slot_q  <= slot_d;
      pos_q   <= pos_d;
      layer_q <= layer_d;
      a_vld_q <= issue;
    end
  end

  // Select neighbor coordinates of the current slot
  assign xv = pick(q_rdata_i[0], pcng_pkg::XSEL[pos_q]);
  assign yv = pick(q_rdata_i[1], pcng_pkg::YSEL[pos_q]);
  assign zv = pick(q_rdata_i[2], pcng_pkg::sel_e'(layer_q));

  // First step: z * ny + y
  always_ff @(posedge clk_i) begin
    if (issue) begin
      a_slot_q <= slot_q;
      a_zy_q   <= ZW'(zv) * ZW'(cnt_i[1]) + ZW'(yv);
      a_x_q    <= xv;
    end
  end

  // Second step: (z * ny + y) * nx + x, registered by the result queue
  assign idx         = IW'(a_zy_q) * IW'(cnt_i[0]) + IW'(a_x_q);
  assign out_push_o  = a_vld_q;
  assign out_wdata_o = {a_slot_q, pcng_pkg::IdxW'(idx), a_slot_q == pcng_pkg::LAST_SLOT};

endmodule

// ===== hw/rtl/periodic_cell_neighbor_generator_core.sv =====
// ----------------------------------------------------------------------------
// periodic_cell_neighbor_generator_core: periodic 27-cell neighbor generator
// Maps a Q16.16 position to its cell and emits the linear indices of the home
// cell and its 26 periodic neighbors, one result per transfer.
// ----------------------------------------------------------------------------
//  channel   handshake             payload
//  --------  --------------------  ------------------------------------------
//  input     push, full            pos_x_i, pos_y_i, pos_z_i
//  result    pop, empty            neighbor_slot_o, cell_index_o, last_o
//  config    cfg_we_i              cfg_idx_i, cfg_wdata_i
//
//  One position gives 27 results from the slot sequencer in the back end,
//  one per cycle while pop stays high and a cell is queued. A position passes
//  the product register, cell queue, first index step and result queue.
//  The front end takes the next position while results still drain; a full
//  cell queue or a full result queue stalls only its own side.
//  Reset clears all control state and loads the register reset values.
// ----------------------------------------------------------------------------
module periodic_cell_neighbor_generator_core #(
  parameter int unsigned MAX_CELLS_PER_AXIS = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  output logic                           full,
  input  logic [pcng_pkg::PosW-1:0]      pos_x_i,
  input  logic [pcng_pkg::PosW-1:0]      pos_y_i,
  input  logic [pcng_pkg::PosW-1:0]      pos_z_i,
  input  logic                           pop,
  output logic                           empty,
  output logic [pcng_pkg::SlotW-1:0]     neighbor_slot_o,
  output logic [pcng_pkg::IdxW-1:0]      cell_index_o,
  output logic                           last_o,
  input  logic                           cfg_we_i,
  input  logic [pcng_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [pcng_pkg::CfgDataW-1:0]  cfg_wdata_i
);

  localparam int unsigned CW = (MAX_CELLS_PER_AXIS > 1) ? $clog2(MAX_CELLS_PER_AXIS) : 1;
  localparam int unsigned NW = $clog2(MAX_CELLS_PER_AXIS + 1);
  localparam int unsigned MidDepth = 2;
  localparam int unsigned OutDepth = 4;
  localparam int unsigned OCW = $clog2(OutDepth + 1);
  localparam int unsigned OW  = pcng_pkg::SlotW + pcng_pkg::IdxW + 1;
  localparam int unsigned MW  = 9 * CW;

  logic [2:0][pcng_pkg::CountW-1:0] cells_q;
  logic [2:0][pcng_pkg::InvW-1:0]   inv_q;
  logic [2:0][NW-1:0]               cnt;

  logic                    mid_push, mid_pop;
  logic [2:0][2:0][CW-1:0] mid_wdata, mid_rdata;
  logic [MW-1:0]           mid_rdata_flat;
  pcng_pkg::q_status_t     mid_st;
  logic [$clog2(MidDepth + 1)-1:0] mid_count;

  logic                    out_push;
  logic [OW-1:0]           out_wdata, out_rdata;
  pcng_pkg::q_status_t     out_st;
  logic [OCW-1:0]          out_count;

  // Write configuration registers; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cells_q <= {3{pcng_pkg::CountW'(1)}};
      inv_q   <= {3{pcng_pkg::InvW'(65536)}};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pcng_pkg::REG_CELLS_X:    cells_q[0] <= cfg_wdata_i[pcng_pkg::CountW-1:0];
        pcng_pkg::REG_CELLS_Y:    cells_q[1] <= cfg_wdata_i[pcng_pkg::CountW-1:0];
        pcng_pkg::REG_CELLS_Z:    cells_q[2] <= cfg_wdata_i[pcng_pkg::CountW-1:0];
        pcng_pkg::REG_INV_SIZE_X: inv_q[0]   <= cfg_wdata_i;
        pcng_pkg::REG_INV_SIZE_Y: inv_q[1]   <= cfg_wdata_i;
        pcng_pkg::REG_INV_SIZE_Z: inv_q[2]   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Clamp cell counts to 1..MAX_CELLS_PER_AXIS
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if (cells_q[a] == '0) begin
        cnt[a] = NW'(1);
      end else if (32'(cells_q[a]) > 32'(MAX_CELLS_PER_AXIS)) begin
        cnt[a] = NW'(MAX_CELLS_PER_AXIS);
      end else begin
        cnt[a] = NW'(cells_q[a]);
      end
    end
  end

  pcng_front #(
    .MAX_CELLS_PER_AXIS(MAX_CELLS_PER_AXIS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .pos_x_i    (pos_x_i),
    .pos_y_i    (pos_y_i),
    .pos_z_i    (pos_z_i),
    .full_o     (full),
    .cnt_i      (cnt),
    .inv_i      (inv_q),
    .q_push_o   (mid_push),
    .q_wdata_o  (mid_wdata),
    .q_status_i (mid_st)
  );

  pcng_fifo #(
    .WIDTH(MW),
    .DEPTH(MidDepth)
  ) u_mid_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (mid_push),
    .wdata_i  (mid_wdata),
    .pop_i    (mid_pop),
    .rdata_o  (mid_rdata_flat),
    .status_o (mid_st),
    .count_o  (mid_count)
  );

  assign mid_rdata = mid_rdata_flat;

  pcng_back #(
    .MAX_CELLS_PER_AXIS(MAX_CELLS_PER_AXIS),
    .OUT_DEPTH(OutDepth)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cnt_i       (cnt),
    .q_rdata_i   (mid_rdata),
    .q_status_i  (mid_st),
    .q_pop_o     (mid_pop),
    .out_push_o  (out_push),
    .out_wdata_o (out_wdata),
    .out_count_i (out_count)
  );

  pcng_fifo #(
    .WIDTH(OW),
    .DEPTH(OutDepth)
  ) u_out_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (out_push),
    .wdata_i  (out_wdata),
    .pop_i    (pop),
    .rdata_o  (out_rdata),
    .status_o (out_st),
    .count_o  (out_count)
  );

  assign empty = out_st.empty;
  assign {neighbor_slot_o, cell_index_o, last_o} = out_rdata;

  // Result queue never overflows: the back end reserves room before issue
  a_out_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_push |-> !out_st.full)
    else $error("result queue written while full");

  // The last flag marks exactly the final slot of a run
  a_last_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (last_o == (neighbor_slot_o == pcng_pkg::LAST_SLOT)))
    else $error("last flag does not match slot");

  // A cell leaves its queue only when its final slot is issued
  a_pop_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_pop |=> out_push && out_wdata[0])
    else $error("cell queue popped before final slot");

  // The cell queue is written only while it has room
  a_mid_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_push |-> (mid_count < ($clog2(MidDepth + 1))'(MidDepth)))
    else $error("cell queue written while full");

endmodule
